/* src/qcl_pkg.sv */
// qcl_pkg: shared constants for the quad corner finder
// no dependencies; used by qcl_div and quad_corners_from_lines

package qcl_pkg;

	localparam int MAX_SEGMENTS_DEF = 64;

	// field widths
	localparam int CRD_W = 12;
	localparam int SEG_W = 4 * CRD_W;
	localparam int FIX_W = 20;
	localparam int CFG_W = 13;
	localparam int FRAC_W = 8;

	// divider operand widths: |nx| << 8 over |d|
	localparam int NUM_W = 47;
	localparam int DEN_W = 27;

	// configuration register indexes and reset values
	localparam logic REG_WIDTH = 1'b0;
	localparam logic REG_HEIGHT = 1'b1;
	localparam logic [CFG_W-1:0] WIDTH_RST = 13'd1296;
	localparam logic [CFG_W-1:0] HEIGHT_RST = 13'd1032;

endpackage

/* src/quad_corners_from_lines.sv */
// quad_corners_from_lines: top level, segment memory, pair sequencer, corner sort
// depends on qcl_pkg and qcl_div
//
//  channel   direction  handshake                 payload
//  segment   in         start & !busy             x_start y_start x_end y_end last_line
//  corner    out        strobe, one cycle each    corner_x corner_y last_corner
//  config    in         cfg_write                 cfg_index cfg_data
//
// a segment is written to the segment memory at acceptance while the memory has room
// after last_line the block is busy: each non-parallel pair passes read, multiply,
// subtract, multiply, subtract and the two 47-step divides; a parallel pair is
// dropped after the first subtract; four kept corners are sorted, then emitted
// reset resets counts, state and config registers; segment memory needs no clearing
// the receiver cannot stall: the four corners go out on consecutive cycles

module quad_corners_from_lines import qcl_pkg::*; #(
	parameter int MAX_SEGMENTS = MAX_SEGMENTS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	// segment transaction
	input  logic             start,
	output logic             busy,
	input  logic [CRD_W-1:0] x_start,
	input  logic [CRD_W-1:0] y_start,
	input  logic [CRD_W-1:0] x_end,
	input  logic [CRD_W-1:0] y_end,
	input  logic             last_line,
	// corner transaction
	output logic             strobe,
	output logic [FIX_W-1:0] corner_x,
	output logic [FIX_W-1:0] corner_y,
	output logic             last_corner,
	// configuration writes
	input  logic             cfg_write,
	input  logic             cfg_index,
	input  logic [CFG_W-1:0] cfg_data
);

	localparam int AW = $clog2(MAX_SEGMENTS);
	localparam int CW = $clog2(MAX_SEGMENTS + 1);
	localparam int LW = CW + 1;

	typedef enum logic [13:0] {
		S_LOAD = 14'b00000000000001,
		S_RD   = 14'b00000000000010,
		S_MUL1 = 14'b00000000000100,
		S_SUB1 = 14'b00000000001000,
		S_MUL2 = 14'b00000000010000,
		S_SUB2 = 14'b00000000100000,
		S_DIVX = 14'b00000001000000,
		S_DIVY = 14'b00000010000000,
		S_KEEP = 14'b00000100000000,
		S_SORT = 14'b00001000000000,
		S_DST  = 14'b00010000000000,
		S_CMP  = 14'b00100000000000,
		S_EMIT = 14'b01000000000000,
		S_IDLE = 14'b10000000000000
	} state_t;

	state_t state_q;

	// configuration registers
	logic [CFG_W-1:0] width_q;
	logic [CFG_W-1:0] height_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WIDTH_RST;
			height_q <= HEIGHT_RST;
		end else if (cfg_write) begin
			unique case (cfg_index)
				REG_WIDTH:  width_q  <= cfg_data;
				REG_HEIGHT: height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// segment memory: one write port, two registered read ports
	logic [SEG_W-1:0] seg_mem [MAX_SEGMENTS];
	logic [SEG_W-1:0] rd_a_q;
	logic [SEG_W-1:0] rd_b_q;
	logic [CW-1:0]    seg_cnt_q;
	logic [LW-1:0]    i_q;
	logic [LW-1:0]    j_q;
	logic             accept;
	logic             seg_wr;

	assign busy   = state_q != S_LOAD;
	assign accept = start && !busy;
	assign seg_wr = accept && (seg_cnt_q < CW'(MAX_SEGMENTS));

	always_ff @(posedge clk) begin
		if (seg_wr)
			seg_mem[seg_cnt_q[AW-1:0]] <= {y_end, x_end, y_start, x_start};
		rd_a_q <= seg_mem[i_q[AW-1:0]];
		rd_b_q <= seg_mem[j_q[AW-1:0]];
	end

	// endpoint fields, zero extended to signed
	logic signed [CRD_W:0] x1, y1, x2, y2, x3, y3, x4, y4;

	always_comb begin
		x1 = {1'b0, rd_a_q[CRD_W-1:0]};
		y1 = {1'b0, rd_a_q[2*CRD_W-1:CRD_W]};
		x2 = {1'b0, rd_a_q[3*CRD_W-1:2*CRD_W]};
		y2 = {1'b0, rd_a_q[4*CRD_W-1:3*CRD_W]};
		x3 = {1'b0, rd_b_q[CRD_W-1:0]};
		y3 = {1'b0, rd_b_q[2*CRD_W-1:CRD_W]};
		x4 = {1'b0, rd_b_q[3*CRD_W-1:2*CRD_W]};
		y4 = {1'b0, rd_b_q[4*CRD_W-1:3*CRD_W]};
	end

	// intersection arithmetic registers
	logic signed [12:0] dx12_q, dy12_q, dx34_q, dy34_q;
	logic signed [25:0] m1_q, m2_q, m3_q, m4_q, m5_q, m6_q;
	logic signed [26:0] d_q;
	logic signed [24:0] pa_q, pb_q;
	logic signed [37:0] n1_q, n2_q, n3_q, n4_q;
	logic signed [38:0] nx_q, ny_q;
	logic [NUM_W-1:0]   qx_q;

	// divider hookup: x first, then y, on the one shared unit
	logic             div_go_q;
	logic             div_done;
	logic [NUM_W-1:0] div_quo;
	logic [NUM_W-1:0] div_num;
	logic [DEN_W-1:0] div_den;
	logic signed [38:0] n_sel;
	logic [38:0]      n_abs;

	always_comb begin
		n_sel   = (state_q == S_DIVY) ? ny_q : nx_q;
		n_abs   = n_sel[38] ? 39'(-n_sel) : 39'(n_sel);
		div_num = {n_abs, {FRAC_W{1'b0}}};
		div_den = d_q[26] ? 27'(-d_q) : 27'(d_q);
	end

	qcl_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_go_q),
		.num    (div_num),
		.den    (div_den),
		.done   (div_done),
		.quo    (div_quo)
	);

	// keep test: negative (signs differ, numerator nonzero) or out-of-frame points fail
	logic              neg_x, neg_y, keep;
	logic [FIX_W-1:0]  new_x, new_y;

	always_comb begin
		neg_x = (nx_q != '0) && (nx_q[38] != d_q[26]);
		neg_y = (ny_q != '0) && (ny_q[38] != d_q[26]);
		keep  = !neg_x && !neg_y
			&& (qx_q < NUM_W'({width_q, {FRAC_W{1'b0}}}))
			&& (div_quo < NUM_W'({height_q, {FRAC_W{1'b0}}}));
		// packed word (y << 20) | x: x bit 20 lands in y bit 0
		new_x = qx_q[FIX_W-1:0];
		new_y = div_quo[FIX_W-1:0] | FIX_W'(qx_q[FIX_W]);
	end

	// pair sequencing
	logic [LW-1:0] n_ext, j_inc, i_inc, i_skip;
	logic          pairs_done, last_j;

	always_comb begin
		n_ext      = LW'(seg_cnt_q);
		j_inc      = j_q + LW'(1);
		i_inc      = i_q + LW'(1);
		i_skip     = i_q + LW'(2);
		pairs_done = j_q >= n_ext;
		last_j     = j_inc >= n_ext;
	end

	// corner store and sort
	logic [FIX_W-1:0] cx_q [4];
	logic [FIX_W-1:0] cy_q [4];
	logic [2:0]       crn_cnt_q;
	logic [1:0]       rank [4];

	// stable rank by x: smaller x, or equal x found earlier
	always_comb begin
		for (int k = 0; k < 4; k++) begin
			rank[k] = '0;
			for (int m = 0; m < 4; m++) begin
				if ((cx_q[m] < cx_q[k]) || ((cx_q[m] == cx_q[k]) && (m < k)))
					rank[k] = rank[k] + 2'd1;
			end
		end
	end

	// distance pass: pass 0 compares entries 1,2; pass 1 compares 2,3
	logic             pass_q;
	logic [1:0]       pa_idx, pb_idx;
	logic [FIX_W-1:0] ddx_a, ddy_a, ddx_b, ddy_b;
	logic [39:0]      sqxa_q, sqya_q, sqxb_q, sqyb_q;
	logic [40:0]      dist_a, dist_b;

	always_comb begin
		pa_idx = {pass_q, ~pass_q};
		pb_idx = {1'b1, pass_q};
		ddx_a  = (cx_q[0] > cx_q[pa_idx]) ? cx_q[0] - cx_q[pa_idx] : cx_q[pa_idx] - cx_q[0];
		ddy_a  = (cy_q[0] > cy_q[pa_idx]) ? cy_q[0] - cy_q[pa_idx] : cy_q[pa_idx] - cy_q[0];
		ddx_b  = (cx_q[0] > cx_q[pb_idx]) ? cx_q[0] - cx_q[pb_idx] : cx_q[pb_idx] - cx_q[0];
		ddy_b  = (cy_q[0] > cy_q[pb_idx]) ? cy_q[0] - cy_q[pb_idx] : cy_q[pb_idx] - cy_q[0];
		dist_a = 41'(sqxa_q) + 41'(sqya_q);
		dist_b = 41'(sqxb_q) + 41'(sqyb_q);
	end

	logic [1:0] out_idx_q;

	// arithmetic and corner datapath
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_MUL1: begin
				dx12_q <= x1 - x2;
				dy12_q <= y1 - y2;
				dx34_q <= x3 - x4;
				dy34_q <= y3 - y4;
				m1_q   <= 26'((x1 - x2) * (y3 - y4));
				m2_q   <= 26'((y1 - y2) * (x3 - x4));
				m3_q   <= 26'(x1 * y2);
				m4_q   <= 26'(y1 * x2);
				m5_q   <= 26'(x3 * y4);
				m6_q   <= 26'(y3 * x4);
			end
			S_SUB1: begin
				d_q  <= 27'(m1_q) - 27'(m2_q);
				pa_q <= 25'(m3_q - m4_q);
				pb_q <= 25'(m5_q - m6_q);
			end
			S_MUL2: begin
				n1_q <= 38'(pa_q * dx34_q);
				n2_q <= 38'(dx12_q * pb_q);
				n3_q <= 38'(pa_q * dy34_q);
				n4_q <= 38'(dy12_q * pb_q);
			end
			S_SUB2: begin
				nx_q <= 39'(n1_q) - 39'(n2_q);
				ny_q <= 39'(n3_q) - 39'(n4_q);
			end
			S_DIVX: begin
				if (div_done)
					qx_q <= div_quo;
			end
			S_DIVY: begin
				if (div_done && keep && (crn_cnt_q < 3'd4)) begin
					cx_q[crn_cnt_q[1:0]] <= new_x;
					cy_q[crn_cnt_q[1:0]] <= new_y;
				end
			end
			S_SORT: begin
				for (int k = 0; k < 4; k++) begin
					cx_q[rank[k]] <= cx_q[k];
					cy_q[rank[k]] <= cy_q[k];
				end
			end
			S_DST: begin
				sqxa_q <= ddx_a * ddx_a;
				sqya_q <= ddy_a * ddy_a;
				sqxb_q <= ddx_b * ddx_b;
				sqyb_q <= ddy_b * ddy_b;
			end
			S_CMP: begin
				// swap only when the nearer slot is strictly farther
				if (dist_a > dist_b) begin
					cx_q[pa_idx] <= cx_q[pb_idx];
					cy_q[pa_idx] <= cy_q[pb_idx];
					cx_q[pb_idx] <= cx_q[pa_idx];
					cy_q[pb_idx] <= cy_q[pa_idx];
				end
			end
			default: ;
		endcase
	end

	// control sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_LOAD;
			seg_cnt_q <= '0;
			crn_cnt_q <= '0;
			i_q       <= '0;
			j_q       <= '0;
			div_go_q  <= 1'b0;
			pass_q    <= 1'b0;
			out_idx_q <= '0;
		end else begin
			div_go_q <= 1'b0;
			unique case (state_q)
				S_LOAD: begin
					if (accept) begin
						if (seg_wr)
							seg_cnt_q <= seg_cnt_q + CW'(1);
						if (last_line) begin
							i_q       <= '0;
							j_q       <= LW'(1);
							crn_cnt_q <= '0;
							state_q   <= S_RD;
						end
					end
				end
				S_RD: begin
					if (pairs_done) begin
						if (crn_cnt_q == 3'd4) begin
							state_q <= S_SORT;
						end else begin
							seg_cnt_q <= '0;
							crn_cnt_q <= '0;
							state_q   <= S_IDLE;
						end
					end else begin
						state_q <= S_MUL1;
					end
				end
				S_MUL1: state_q <= S_SUB1;
				S_SUB1: state_q <= S_MUL2;
				S_MUL2: begin
					// parallel or degenerate pair: move on
					if (d_q == '0) begin
						if (last_j) begin
							i_q <= i_inc;
							j_q <= i_skip;
						end else begin
							j_q <= j_inc;
						end
						state_q <= S_RD;
					end else begin
						state_q <= S_SUB2;
					end
				end
				S_SUB2: begin
					div_go_q <= 1'b1;
					state_q  <= S_DIVX;
				end
				S_DIVX: begin
					if (div_done) begin
						div_go_q <= 1'b1;
						state_q  <= S_DIVY;
					end
				end
				S_DIVY: begin
					if (div_done) begin
						if (keep && (crn_cnt_q < 3'd5))
							crn_cnt_q <= crn_cnt_q + 3'd1;
						state_q <= S_KEEP;
					end
				end
				S_KEEP: begin
					if (last_j) begin
						i_q <= i_inc;
						j_q <= i_skip;
					end else begin
						j_q <= j_inc;
					end
					state_q <= S_RD;
				end
				S_SORT: begin
					pass_q  <= 1'b0;
					state_q <= S_DST;
				end
				S_DST: state_q <= S_CMP;
				S_CMP: begin
					if (pass_q) begin
						out_idx_q <= '0;
						state_q   <= S_EMIT;
					end else begin
						pass_q  <= 1'b1;
						state_q <= S_DST;
					end
				end
				S_EMIT: begin
					out_idx_q <= out_idx_q + 2'd1;
					if (out_idx_q == 2'd3) begin
						seg_cnt_q <= '0;
						crn_cnt_q <= '0;
						state_q   <= S_LOAD;
					end
				end
				S_IDLE: state_q <= S_LOAD;
				default: state_q <= S_LOAD;
			endcase
		end
	end

	// corner transaction: one cycle per corner, no back-pressure
	assign strobe      = state_q == S_EMIT;
	assign corner_x    = cx_q[out_idx_q];
	assign corner_y    = cy_q[out_idx_q];
	assign last_corner = out_idx_q == 2'd3;

endmodule

/* src/qcl_div.sv */
// qcl_div: restoring unsigned divider, one quotient bit per cycle
// depends on qcl_pkg for operand widths

module qcl_div import qcl_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [NUM_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	output logic             done,
	output logic [NUM_W-1:0] quo
);

	localparam int STEP_W = $clog2(NUM_W + 1);

	logic              run_q;
	logic              done_q;
	logic [STEP_W-1:0] cnt_q;
	logic [DEN_W-1:0]  rem_q;
	logic [DEN_W-1:0]  den_q;
	logic [NUM_W-1:0]  quo_q;

	logic [DEN_W:0]    trial;
	logic              ge;

	always_comb begin
		trial = {rem_q, quo_q[NUM_W-1]};
		ge    = trial >= {1'b0, den_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= STEP_W'(NUM_W);
			end else if (run_q) begin
				cnt_q <= cnt_q - STEP_W'(1);
				if (cnt_q == STEP_W'(1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			den_q <= den;
			quo_q <= num;
		end else if (run_q) begin
			rem_q <= ge ? DEN_W'(trial - {1'b0, den_q}) : trial[DEN_W-1:0];
			quo_q <= {quo_q[NUM_W-2:0], ge};
		end
	end

	assign done = done_q;
	assign quo  = quo_q;

endmodule

/* tb/tb_top.sv */
// tb_top: self-checking testbench for quad_corners_from_lines
// depends on qcl_pkg and the quad_corners_from_lines rtl; segment sets go in,
// predicted corners are checked one by one as each strobed corner comes out

module tb_top;
	import qcl_pkg::*;

	typedef struct {
		logic [CRD_W-1:0] xs, ys, xe, ye;
		logic             last;
	} seg_t;

	typedef struct {
		logic [FIX_W-1:0] cx, cy;
		logic             last;
	} corner_t;

	localparam int SEG_CAP = MAX_SEGMENTS_DEF;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             start = 1'b0;
	logic             busy;
	logic             strobe;
	logic [FIX_W-1:0] corner_x, corner_y;
	logic             last_corner;
	logic             cfg_write = 1'b0;
	logic             cfg_index = REG_WIDTH;
	logic [CFG_W-1:0] cfg_data = '0;
	seg_t             cur = '{default: '0};

	seg_t    pending_segs[$];
	corner_t corners_due[$];
	bit      failed = 1'b0;

	// shadow copy of the block's registers and segment memory
	longint  img_w = WIDTH_RST;
	longint  img_h = HEIGHT_RST;
	seg_t    seg_mem[$];

	int      burst_left = 0;
	int      gap_left = 0;

	quad_corners_from_lines DUT (
		.clk(clk), .arst_n(arst_n),
		.start(start), .busy(busy),
		.x_start(cur.xs), .y_start(cur.ys), .x_end(cur.xe), .y_end(cur.ye),
		.last_line(cur.last),
		.strobe(strobe), .corner_x(corner_x), .corner_y(corner_y),
		.last_corner(last_corner),
		.cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic longint floor_quot(longint n, longint d);
		longint q;
		q = n / d;
		if ((n % d) != 0 && ((n < 0) != (d < 0)))
			q--;
		return q;
	endfunction

	// squared distance between two fixed-point corners
	function automatic longint dist2(longint ax, longint ay, longint bx, longint by);
		return (ax - bx) * (ax - bx) + (ay - by) * (ay - by);
	endfunction

	// append a segment to the driver's queue
	function automatic void add_pending(seg_t s);
		pending_segs.insert(pending_segs.size(), s);
	endfunction

	// intersect all stored pairs, keep in-frame points, and when exactly four are kept sort and queue them
	task automatic find_corners();
		longint x1, y1, x2, y2, x3, y3, x4, y4, d, pa, pb, qx, qy, t;
		longint kx[4], ky[4];
		int     kept, j;
		corner_t c;
		kept = 0;
		for (int a = 0; a < seg_mem.size(); a++) begin
			for (int b = a + 1; b < seg_mem.size(); b++) begin
				x1 = seg_mem[a].xs; y1 = seg_mem[a].ys;
				x2 = seg_mem[a].xe; y2 = seg_mem[a].ye;
				x3 = seg_mem[b].xs; y3 = seg_mem[b].ys;
				x4 = seg_mem[b].xe; y4 = seg_mem[b].ye;
				d = (x1 - x2) * (y3 - y4) - (y1 - y2) * (x3 - x4);
				if (d == 0)
					continue;
				pa = x1 * y2 - y1 * x2;
				pb = x3 * y4 - y3 * x4;
				qx = floor_quot((pa * (x3 - x4) - (x1 - x2) * pb) * 256, d);
				qy = floor_quot((pa * (y3 - y4) - (y1 - y2) * pb) * 256, d);
				if (qx < 0 || qy < 0 || qx >= img_w * 256 || qy >= img_h * 256)
					continue;
				// packed word (y << 20) | x: x bit 20 lands in y bit 0
				if (kept < 4) begin
					kx[kept] = qx & 64'hFFFFF;
					ky[kept] = (qy | (qx >> 20)) & 64'hFFFFF;
				end
				if (kept < 5)
					kept++;
			end
		end
		if (kept != 4)
			return;
		// stable insertion sort by x
		for (int i = 1; i < 4; i++) begin
			qx = kx[i]; qy = ky[i];
			j = i;
			while (j > 0 && kx[j-1] > qx) begin
				kx[j] = kx[j-1]; ky[j] = ky[j-1];
				j--;
			end
			kx[j] = qx; ky[j] = qy;
		end
		// one swap pass by distance from the leftmost corner
		for (int i = 1; i < 3; i++) begin
			if (dist2(kx[0], ky[0], kx[i], ky[i]) > dist2(kx[0], ky[0], kx[i+1], ky[i+1])) begin
				t = kx[i]; kx[i] = kx[i+1]; kx[i+1] = t;
				t = ky[i]; ky[i] = ky[i+1]; ky[i+1] = t;
			end
		end
		for (int i = 0; i < 4; i++) begin
			c.cx = kx[i][FIX_W-1:0];
			c.cy = ky[i][FIX_W-1:0];
			c.last = (i == 3);
			corners_due.insert(corners_due.size(), c);
		end
	endtask

	task automatic predict_segment(seg_t s);
		if (seg_mem.size() < SEG_CAP)
			seg_mem.insert(seg_mem.size(), s);
		if (s.last) begin
			find_corners();
			seg_mem.delete();
		end
	endtask

	// driver: bursts of segment transactions separated by random gaps
	always @(posedge clk) begin
		if (arst_n) begin
			if (start && !busy)
				predict_segment(cur);
			if (!(start && busy)) begin
				if (gap_left > 0) begin
					gap_left--;
					start <= 1'b0;
				end else if (pending_segs.size() > 0) begin
					cur <= pending_segs.pop_front();
					start <= 1'b1;
					if (burst_left == 0) begin
						// some bursts end with no gap at all
						gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
						burst_left = $urandom_range(0, 12);
					end else begin
						burst_left--;
					end
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	// monitor: every strobed corner must match the oldest prediction
	always @(posedge clk) begin
		corner_t e;
		if (arst_n && strobe) begin
			if (corners_due.size() == 0) begin
				$display("%0t: unexpected corner x=%0d y=%0d last=%0b",
					$time, corner_x, corner_y, last_corner);
				failed = 1'b1;
			end else begin
				e = corners_due.pop_front();
				if (corner_x !== e.cx) begin
					$display("%0t: corner_x expected %0d actual %0d", $time, e.cx, corner_x);
					failed = 1'b1;
				end
				if (corner_y !== e.cy) begin
					$display("%0t: corner_y expected %0d actual %0d", $time, e.cy, corner_y);
					failed = 1'b1;
				end
				if (last_corner !== e.last) begin
					$display("%0t: last_corner expected %0b actual %0b",
						$time, e.last, last_corner);
					failed = 1'b1;
				end
			end
		end
	end

	function automatic seg_t mk(int xs, int ys, int xe, int ye, bit last);
		seg_t s;
		s.xs = CRD_W'(xs); s.ys = CRD_W'(ys); s.xe = CRD_W'(xe); s.ye = CRD_W'(ye);
		s.last = last;
		return s;
	endfunction

	function automatic int clip(int v);
		return (v < 0) ? 0 : (v > 4095) ? 4095 : v;
	endfunction

	function automatic seg_t noise_seg();
		return mk($urandom_range(0, 4095), $urandom_range(0, 4095),
			$urandom_range(0, 4095), $urandom_range(0, 4095), 1'b0);
	endfunction

	// one set outlining a random quadrilateral, sides shuffled, optional noise lines, a segment sometimes dropped
	task automatic queue_quad(int noise);
		int   w, h, px[4], py[4], k, n;
		seg_t set[$];
		seg_t s;
		w = (img_w > 4095 || img_w < 16) ? 4095 : int'(img_w);
		h = (img_h > 4095 || img_h < 16) ? 4095 : int'(img_h);
		px[0] = $urandom_range(w / 16, 3 * w / 8);  py[0] = $urandom_range(h / 16, 3 * h / 8);
		px[1] = $urandom_range(5 * w / 8, 15 * w / 16); py[1] = $urandom_range(h / 16, 3 * h / 8);
		px[2] = $urandom_range(5 * w / 8, 15 * w / 16); py[2] = $urandom_range(5 * h / 8, 15 * h / 16);
		px[3] = $urandom_range(w / 16, 3 * w / 8);  py[3] = $urandom_range(5 * h / 8, 15 * h / 16);
		for (int i = 0; i < 4; i++) begin
			k = (i + 1) % 4;
			// small jitter keeps the intersections off the pixel grid
			s = mk(clip(px[i] + $urandom_range(0, 4) - 2), clip(py[i] + $urandom_range(0, 4) - 2),
				clip(px[k] + $urandom_range(0, 4) - 2), clip(py[k] + $urandom_range(0, 4) - 2), 1'b0);
			if ($urandom_range(0, 1)) begin
				s = mk(s.xe, s.ye, s.xs, s.ys, 1'b0);
			end
			set.insert($urandom_range(0, set.size()), s);
		end
		for (int i = 0; i < noise; i++)
			set.insert($urandom_range(0, set.size()), noise_seg());
		// broken sets: drop a segment now and then
		if ($urandom_range(0, 9) == 0)
			set.delete($urandom_range(0, set.size() - 1));
		n = set.size();
		set[n-1].last = 1'b1;
		foreach (set[i])
			add_pending(set[i]);
	endtask

	task automatic queue_random(int sets);
		for (int i = 0; i < sets; i++) begin
			if ($urandom_range(0, 7) == 0) begin
				// pure noise set
				for (int k = $urandom_range(0, 5); k > 0; k--)
					add_pending(noise_seg());
				add_pending(mk($urandom_range(0, 4095), $urandom_range(0, 4095),
					$urandom_range(0, 4095), $urandom_range(0, 4095), 1'b1));
			end else begin
				queue_quad(($urandom_range(0, 3) == 0) ? $urandom_range(1, 2) : 0);
			end
		end
	endtask

	// wait until the driver has drained and the block has finished its set
	task automatic wait_idle();
		while (pending_segs.size() > 0 || start)
			@(posedge clk);
		repeat (3) @(posedge clk);
		while (busy || corners_due.size() > 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic write_reg(logic idx, logic [CFG_W-1:0] val);
		@(posedge clk);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_write <= 1'b0;
		if (idx == REG_WIDTH)
			img_w = val;
		else
			img_h = val;
	endtask

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: a clean rectangle, extremes, parallel and degenerate pairs
		add_pending(mk(100, 100, 1100, 100, 0));
		add_pending(mk(1100, 100, 1100, 900, 0));
		add_pending(mk(1100, 900, 100, 900, 0));
		add_pending(mk(100, 900, 100, 100, 1));
		add_pending(mk(0, 0, 4095, 4095, 0));
		add_pending(mk(4095, 0, 0, 4095, 0));
		add_pending(mk(0, 4095, 4095, 0, 0));
		add_pending(mk(4095, 4095, 4095, 4095, 1));
		// single segment set
		add_pending(mk(4095, 4095, 0, 0, 1));
		// parallel pair and a point-like segment
		add_pending(mk(10, 20, 500, 20, 0));
		add_pending(mk(10, 40, 500, 40, 0));
		add_pending(mk(7, 7, 7, 7, 1));
		// tilted quad whose corners are the shared endpoints
		add_pending(mk(201, 150, 903, 173, 0));
		add_pending(mk(903, 173, 950, 811, 0));
		add_pending(mk(950, 811, 203, 790, 0));
		add_pending(mk(203, 790, 201, 150, 1));
		// five lines: more than four points
		add_pending(mk(100, 100, 1100, 100, 0));
		add_pending(mk(1100, 100, 1100, 900, 0));
		add_pending(mk(1100, 900, 100, 900, 0));
		add_pending(mk(100, 900, 100, 100, 0));
		add_pending(mk(0, 0, 1200, 1000, 1));
		wait_idle();

		queue_random(25);
		wait_idle();

		// largest frame the fields allow, then beyond it
		write_reg(REG_WIDTH, 13'd4096);
		write_reg(REG_HEIGHT, 13'd4096);
		queue_random(12);
		wait_idle();
		write_reg(REG_WIDTH, 13'h1FFF);
		write_reg(REG_HEIGHT, 13'h1FFF);
		queue_random(6);
		wait_idle();

		// zero and one pixel frames keep nothing or almost nothing
		write_reg(REG_WIDTH, 13'd0);
		queue_random(4);
		wait_idle();
		write_reg(REG_WIDTH, 13'd1);
		write_reg(REG_HEIGHT, 13'd1);
		queue_random(3);
		add_pending(mk(0, 0, 10, 0, 0));
		add_pending(mk(0, 0, 0, 10, 1));
		wait_idle();

		write_reg(REG_WIDTH, 13'd2000);
		write_reg(REG_HEIGHT, 13'd1500);
		queue_random(12);
		wait_idle();

		// overflowing set: a quad, then parallel filler past the capacity
		write_reg(REG_WIDTH, WIDTH_RST);
		write_reg(REG_HEIGHT, HEIGHT_RST);
		queue_quad(0);
		void'(pending_segs.pop_back());
		begin
			seg_t q;
			q = pending_segs.pop_back();
			q.last = 1'b0;
			add_pending(q);
		end
		add_pending(mk(150, 100, 150, 900, 0));
		for (int i = 0; i < SEG_CAP; i++)
			add_pending(mk(0, 4000 - i, 4095, 4000 - i, 0));
		add_pending(mk(0, 3000, 4095, 3000, 1));
		wait_idle();

		queue_random(10);
		wait_idle();
		repeat (50) @(posedge clk);

		if (!failed && corners_due.size() == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

	// watchdog
	initial begin
		#50000000;
		$display("TEST FAILED");
		$finish;
	end

endmodule

/* files.f */
src/qcl_pkg.sv
src/qcl_div.sv
src/quad_corners_from_lines.sv
tb/tb_top.sv
